FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file, mi3_checker.sv.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

// antecedent implies consequent (consequent may hold a ## delay)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("%m: implication failed");

`endif

FILE: rtl/core/mi3_pkg.sv
// Types, widths and cofactor index tables for the 3x3 matrix inverse.
// No dependencies; used by the top level and its checker.
package mi3_pkg;

  localparam int ELEM_W = 32;   // Q16.16 element
  localparam int PROD_W = 64;   // element product
  localparam int COF_W  = 65;   // signed cofactor
  localparam int CMAG_W = 64;   // cofactor magnitude
  localparam int TERM_W = 96;   // magnitude of element times cofactor
  localparam int DET_W  = 98;   // signed determinant
  localparam int DMAG_W = 97;   // determinant magnitude
  localparam int QR_W   = 33;   // rounded quotient
  localparam int NLANE  = 9;
  localparam int NSTEP  = 32;   // quotient bits, one per stage
  // register stages from request to result strobe
  localparam int NSTAGE = NSTEP + 11;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // cofactor k = a[P]*a[Q] - a[R]*a[S], row-major element indexes
  localparam logic [3:0] CF_P [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] CF_Q [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] CF_R [NLANE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] CF_S [NLANE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  localparam logic [QR_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QR_W-1:0] LIM_NEG = 33'h0_8000_0000;

endpackage

FILE: rtl/core/matrix3_inverse_cofactor.sv
// The result strobe (done) rises with the registered result of the last stage, S43.
// Throughput: one matrix per cycle; busy stays low, the pipeline never stalls.
// The 32 stages of the restoring divider, one quotient bit each, set the depth.
// Reset clears the valid bits of every stage; data registers are not reset.
// Depends on mi3_pkg.
module matrix3_inverse_cofactor (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mi3_pkg::elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic          done,
  output mi3_pkg::elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22,
  output logic          singular,
  output logic          saturated
);
  import mi3_pkg::*;

  elem_t a_in [NLANE];
  assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  // valid bits, one per stage
  logic [NSTAGE-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], start};
    end
  end
  assign busy = 1'b0;
  assign done = vld[NSTAGE-1];

  // S1: cofactor products
  logic signed [PROD_W-1:0] prod_p [NLANE];
  logic signed [PROD_W-1:0] prod_r [NLANE];
  elem_t a0_s1 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      prod_p[k] <= PROD_W'(a_in[CF_P[k]]) * PROD_W'(a_in[CF_Q[k]]);
      prod_r[k] <= PROD_W'(a_in[CF_R[k]]) * PROD_W'(a_in[CF_S[k]]);
    end
    a0_s1 <= '{a00, a01, a02};
  end

  // S2: cofactors
  logic signed [COF_W-1:0] cof [NLANE];
  elem_t a0_s2 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      cof[k] <= COF_W'(prod_p[k]) - COF_W'(prod_r[k]);
    end
    a0_s2 <= a0_s1;
  end

  // S3: magnitudes and signs; cofactors carried to the divider from here
  logic [CMAG_W-1:0] cmag_d [7][NLANE];
  logic [NLANE-1:0]  cneg_d [7];
  logic [ELEM_W-1:0] amag_s3 [3];
  logic [2:0]        aneg_s3;
  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      cmag_d[0][k] <= cof[k][COF_W-1] ? CMAG_W'(-cof[k]) : CMAG_W'(cof[k]);
      cneg_d[0][k] <= cof[k][COF_W-1];
    end
    for (int st = 1; st < 7; st++) begin
      cmag_d[st] <= cmag_d[st-1];
      cneg_d[st] <= cneg_d[st-1];
    end
    for (int j = 0; j < 3; j++) begin
      amag_s3[j] <= a0_s2[j][ELEM_W-1] ? ELEM_W'(-a0_s2[j]) : ELEM_W'(a0_s2[j]);
      aneg_s3[j] <= a0_s2[j][ELEM_W-1];
    end
  end

  // S4: determinant partial products, row 0 times first cofactor column
  logic [PROD_W-1:0] pp_lo [3];
  logic [PROD_W-1:0] pp_hi [3];
  logic [2:0]        tneg_s4;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pp_lo[j]   <= PROD_W'(amag_s3[j]) * PROD_W'(cmag_d[0][3*j][31:0]);
      pp_hi[j]   <= PROD_W'(amag_s3[j]) * PROD_W'(cmag_d[0][3*j][63:32]);
      tneg_s4[j] <= aneg_s3[j] ^ cneg_d[0][3*j];
    end
  end

  // S5: combine partial products
  logic [TERM_W-1:0] tmag [3];
  logic [2:0]        tneg_s5;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      tmag[j] <= (TERM_W'(pp_hi[j]) << 32) + TERM_W'(pp_lo[j]);
    end
    tneg_s5 <= tneg_s4;
  end

  // S6: apply sign
  logic signed [DET_W-1:0] term [3];
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      term[j] <= tneg_s5[j] ? -$signed(DET_W'(tmag[j])) : $signed(DET_W'(tmag[j]));
    end
  end

  // S7, S8: determinant sum
  logic signed [DET_W-1:0] sum01, term2, det;
  always_ff @(posedge clk) begin
    sum01 <= term[0] + term[1];
    term2 <= term[2];
    det   <= sum01 + term2;
  end

  // S9: determinant magnitude, sign, zero
  logic [DMAG_W-1:0] dmag_s9;
  logic              dneg_s9, dzero_s9;
  always_ff @(posedge clk) begin
    dmag_s9  <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
    dneg_s9  <= det[DET_W-1];
    dzero_s9 <= (det == '0);
  end

  // S10: divider entry; quotient overflows when |cof| >= |det|
  logic [DMAG_W-1:0] rem  [NSTEP+1][NLANE];
  logic [NSTEP-1:0]  quo  [NSTEP+1][NLANE];
  logic [NLANE-1:0]  ovf  [NSTEP+1];
  logic [NLANE-1:0]  lneg [NSTEP+1];
  logic [DMAG_W-1:0] dmag [NSTEP+1];
  logic              dzero [NSTEP+1];
  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      rem[0][k]  <= DMAG_W'(cmag_d[6][k]);
      quo[0][k]  <= '0;
      ovf[0][k]  <= DMAG_W'(cmag_d[6][k]) >= dmag_s9;
      lneg[0][k] <= cneg_d[6][k] ^ dneg_s9;
    end
    dmag[0]  <= dmag_s9;
    dzero[0] <= dzero_s9;
  end

  // S11..S42: restoring division, one quotient bit per stage
  for (genvar s = 1; s <= NSTEP; s++) begin : g_step
    logic [DMAG_W:0] r2   [NLANE];
    logic [DMAG_W:0] diff [NLANE];
    logic [NLANE-1:0] ge;
    for (genvar k = 0; k < NLANE; k++) begin : g_lane
      assign r2[k]   = {rem[s-1][k], 1'b0};
      assign diff[k] = r2[k] - {1'b0, dmag[s-1]};
      assign ge[k]   = r2[k] >= {1'b0, dmag[s-1]};
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < NLANE; k++) begin
        rem[s][k] <= ge[k] ? diff[k][DMAG_W-1:0] : r2[k][DMAG_W-1:0];
        quo[s][k] <= {quo[s-1][k][NSTEP-2:0], ge[k]};
      end
      ovf[s]   <= ovf[s-1];
      lneg[s]  <= lneg[s-1];
      dmag[s]  <= dmag[s-1];
      dzero[s] <= dzero[s-1];
    end
  end

  // S43: round half away from zero, saturate, sign; all zero when singular
  logic [QR_W-1:0]   qr   [NLANE];
  logic [QR_W-1:0]   lim  [NLANE];
  logic [ELEM_W-1:0] mag  [NLANE];
  logic [NLANE-1:0]  satl;
  elem_t             res  [NLANE];
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      qr[k]   = QR_W'(quo[NSTEP][k]) +
                QR_W'({rem[NSTEP][k], 1'b0} >= {1'b0, dmag[NSTEP]});
      lim[k]  = lneg[NSTEP][k] ? LIM_NEG : LIM_POS;
      satl[k] = ovf[NSTEP][k] || (qr[k] > lim[k]);
      mag[k]  = satl[k] ? lim[k][ELEM_W-1:0] : qr[k][ELEM_W-1:0];
      res[k]  = lneg[NSTEP][k] ? -$signed(mag[k]) : $signed(mag[k]);
      if (dzero[NSTEP]) begin
        res[k]  = '0;
        satl[k] = 1'b0;
      end
    end
  end

  elem_t b_r [NLANE];
  always_ff @(posedge clk) begin
    b_r       <= res;
    singular  <= dzero[NSTEP];
    saturated <= |satl;
  end

  assign b00 = b_r[0];
  assign b01 = b_r[1];
  assign b02 = b_r[2];
  assign b10 = b_r[3];
  assign b11 = b_r[4];
  assign b12 = b_r[5];
  assign b20 = b_r[6];
  assign b21 = b_r[7];
  assign b22 = b_r[8];

endmodule

FILE: rtl/core/mi3_checker.sv
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
// Depends on mi3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mi3_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input mi3_pkg::elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22,
  input logic          singular,
  input logic          saturated
);
  import mi3_pkg::*;

  // all nine result elements are zero
  logic b_zero;
  assign b_zero = (b00 == '0) && (b01 == '0) && (b02 == '0) &&
                  (b10 == '0) && (b11 == '0) && (b12 == '0) &&
                  (b20 == '0) && (b21 == '0) && (b22 == '0);

  // pipeline never pushes back
  `ASSERT_NEVER(a_no_busy, clk, rst, busy)
  // a singular result is all zeros and never flagged as clipped
  `ASSERT_IMPLIES(a_sing_zero, clk, rst, done && singular, (!saturated && b_zero))
  // every request produces a result after the fixed latency
  `ASSERT_IMPLIES(a_lat_fwd, clk, rst, start && !busy, ##NSTAGE done)
  // no result without a request at the matching time
  `ASSERT_IMPLIES(a_lat_back, clk, rst, done, $past(start && !busy, NSTAGE))

endmodule

bind matrix3_inverse_cofactor mi3_checker u_mi3_checker (.*);

FILE: tb/matrix3_inverse_cofactor_tb.sv
// Testbench for the 3x3 Q16.16 matrix inverse: directed and random matrices are
// checked against a built-in exact predictor. Depends on mi3_pkg and the block.
`timescale 1ns / 100ps

module matrix3_inverse_cofactor_tb;
  import mi3_pkg::*;

  typedef logic [8:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    mat_t inv;
    logic sing;
    logic sat;
  } inv_result_t;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam int DRAIN_CYCLES = NSTAGE + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, singular, saturated;
  elem_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
  elem_t a20 = '0, a21 = '0, a22 = '0;
  elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22;

  inv_result_t pending_inverses[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_singular = 0;
  int n_saturated = 0;

  matrix3_inverse_cofactor i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
    .a20(a20), .a21(a21), .a22(a22),
    .done(done),
    .b00(b00), .b01(b01), .b02(b02), .b10(b10), .b11(b11), .b12(b12),
    .b20(b20), .b21(b21), .b22(b22),
    .singular(singular), .saturated(saturated)
  );

  always #2 clk = ~clk;

  // 2x2 minor a[p]*a[q] - a[r]*a[s], exact
  function automatic logic signed [127:0] minor2(input mat_t m, input int p, q, r, s);
    logic signed [127:0] ep, eq, er, es;
    ep = $signed(m[p]);
    eq = $signed(m[q]);
    er = $signed(m[r]);
    es = $signed(m[s]);
    return ep * eq - er * es;
  endfunction

  // exact adjugate over determinant, rounded half away from zero, saturated
  function automatic inv_result_t invert_q16(input mat_t m);
    inv_result_t res;
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic [127:0] num, den, quo, rem, lim;
    logic neg;
    cof[0] = minor2(m, 4, 8, 5, 7);
    cof[1] = minor2(m, 2, 7, 1, 8);
    cof[2] = minor2(m, 1, 5, 2, 4);
    cof[3] = minor2(m, 5, 6, 3, 8);
    cof[4] = minor2(m, 0, 8, 2, 6);
    cof[5] = minor2(m, 2, 3, 0, 5);
    cof[6] = minor2(m, 3, 7, 4, 6);
    cof[7] = minor2(m, 1, 6, 0, 7);
    cof[8] = minor2(m, 0, 4, 1, 3);
    det = $signed(m[0]) * cof[0] + $signed(m[1]) * cof[3] + $signed(m[2]) * cof[6];
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    den = det[127] ? -det : det;
    for (int k = 0; k < 9; k++) begin
      neg = cof[k][127] ^ det[127];
      num = (cof[k][127] ? -cof[k] : cof[k]) << 32;
      quo = num / den;
      rem = num % den;
      if ((rem << 1) >= den) quo = quo + 1;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > lim) begin
        quo = lim;
        res.sat = 1'b1;
      end
      res.inv[k] = neg ? 32'(-quo) : 32'(quo);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  // issue one request and hold off for the given number of cycles after it
  task automatic send_matrix(input mat_t m, input int gap);
    start <= 1'b1;
    a00 <= m[0]; a01 <= m[1]; a02 <= m[2];
    a10 <= m[3]; a11 <= m[4]; a12 <= m[5];
    a20 <= m[6]; a21 <= m[7]; a22 <= m[8];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_inverses.push_back(invert_q16(m));
    n_requests++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_done();
    start <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    mat_t got;
    inv_result_t exp;
    if (!rst && done) begin
      got = {b22, b21, b20, b12, b11, b10, b02, b01, b00};
      if (pending_inverses.size() == 0) begin
        report_mismatch("result with no request outstanding, done", 32'(done), 32'd0);
      end else begin
        exp = pending_inverses.pop_front();
        n_results++;
        if (exp.sing) n_singular++;
        if (exp.sat) n_saturated++;
        for (int k = 0; k < 9; k++)
          if (got[k] !== exp.inv[k])
            report_mismatch($sformatf("b%0d%0d", k / 3, k % 3), got[k], exp.inv[k]);
        if (singular !== exp.sing)
          report_mismatch("singular", 32'(singular), 32'(exp.sing));
        if (saturated !== exp.sat)
          report_mismatch("saturated", 32'(saturated), 32'(exp.sat));
      end
    end
  end

  function automatic mat_t diag3(input logic [31:0] d0, d1, d2);
    mat_t m;
    m = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  function automatic logic [31:0] small_elem();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // random matrix of one of several shapes
  function automatic mat_t random_matrix();
    mat_t m;
    int shape;
    shape = $urandom_range(0, 5);
    for (int k = 0; k < 9; k++) begin
      case (shape)
        0: m[k] = $urandom;
        1, 2: m[k] = small_elem();
        default: m[k] = $signed($urandom) >>> $urandom_range(0, 31);
      endcase
    end
    // singular: a repeated row or column
    if (shape == 2) begin
      if ($urandom_range(0, 1)) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end else begin
        m[1] = m[0]; m[4] = m[3]; m[7] = m[6];
      end
    end
    // diagonal of whole numbers from 1 to 64, the middle one negated
    if (shape == 5) begin
      m[0] = $urandom_range(1, 64) << 16;
      m[4] = -($urandom_range(1, 64) << 16);
      m[8] = $urandom_range(1, 64) << 16;
    end
    return m;
  endfunction

  task automatic test_special_matrices();
    mat_t m;
    send_matrix(diag3(ONE_Q16, ONE_Q16, ONE_Q16), 0);
    send_matrix(diag3(-ONE_Q16, -ONE_Q16, -ONE_Q16), 1);
    send_matrix('0, 0);
    send_matrix({9{32'h7FFF_FFFF}}, 0);
    send_matrix({9{32'h8000_0000}}, 2);
    send_matrix(diag3(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_matrix(diag3(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_matrix(diag3(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001), 3);
    send_matrix(diag3(32'h0000_0003, ONE_Q16, 32'h0002_0000), 0);
    send_matrix(diag3(32'h0003_0000, 32'h0007_0000, 32'hFFFD_0000), 0);
    // rounding ties: b00 is exactly +0.5 and -0.5 steps
    m = diag3(32'd0, 32'd1, ONE_Q16);
    m[1] = 32'hFFFE_0000;
    m[3] = 32'h0001_0000;
    send_matrix(m, 0);
    m[4] = 32'hFFFF_FFFF;
    send_matrix(m, 1);
    // permutation and a rank-two matrix
    m = '0;
    m[1] = ONE_Q16; m[5] = ONE_Q16; m[6] = ONE_Q16;
    send_matrix(m, 0);
    m = '0;
    m[0] = ONE_Q16; m[4] = ONE_Q16;
    send_matrix(m, 0);
    // alternating bit patterns
    send_matrix({9{32'hAAAA_AAAA}}, 0);
    m = {9{32'h5555_5555}};
    m[4] = 32'hAAAA_AAAA;
    send_matrix(m, 4);
  endtask

  task automatic test_random_matrices(input int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0 && $urandom_range(0, 15) == 0) burst = $urandom_range(10, 60);
      if (n == count / 2) wait_all_done();
      if (burst > 0) begin
        burst--;
        send_matrix(random_matrix(), 0);
      end else begin
        send_matrix(random_matrix(), $urandom_range(0, 7));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_special_matrices();
    wait_all_done();
    test_random_matrices(1400);
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests, %0d results: %0d singular, %0d saturated.",
             n_requests, n_results, n_singular, n_saturated);
    if (errors == 0 && pending_inverses.size() == 0)
      $display("matrix3_inverse_cofactor test passed");
    else
      $display("matrix3_inverse_cofactor test failed");
    $finish;
  end

  initial begin
    #1ms;
    $display("Timeout with %0d results outstanding", pending_inverses.size());
    $display("matrix3_inverse_cofactor test failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mi3_pkg.sv
rtl/core/matrix3_inverse_cofactor.sv
rtl/core/mi3_checker.sv
tb/matrix3_inverse_cofactor_tb.sv
